// File: rtl/plc_pkg.sv
`default_nettype none

package plc_pkg;

  localparam int unsigned PageSizeDef  = 64;
  localparam int unsigned AddrWidthDef = 24;

  localparam logic [7:0] FillByte    = 8'hFF;
  localparam logic [1:0] TargetFlash = 2'd0;

  typedef enum logic [2:0] {
    MODE_PING   = 3'd0,
    MODE_TARGET = 3'd1,
    MODE_RESET  = 3'd2,
    MODE_ADDR   = 3'd3,
    MODE_DATA   = 3'd4,
    MODE_FINISH = 3'd5,
    MODE_EXIT   = 3'd6,
    MODE_DEAF   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PING  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LEAVE = 2'd2
  } kind_e;

  // one classified command as handed from front to back
  typedef struct packed {
    logic        wr;
    logic        clear;
    logic        commit;
    logic        reply;
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] req;
    logic [7:0]  seq;
    logic [15:0] crc;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/plc_front.sv
`default_nettype none

module plc_front #(
  parameter int unsigned PAGE_SIZE  = plc_pkg::PageSizeDef,
  parameter int unsigned ADDR_WIDTH = plc_pkg::AddrWidthDef,
  localparam int unsigned IdxW      = $clog2(PAGE_SIZE)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            mode_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic [1:0]            target_memory_i,
  input  wire logic [23:0]           start_address_i,
  input  wire logic [15:0]           requester_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output plc_pkg::cmd_t              q_cmd_o,
  output logic [ADDR_WIDTH-1:0]      q_addr_o,
  output logic [IdxW-1:0]            q_idx_o
);
  import plc_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PAGE_SIZE - 1);
  localparam logic [ADDR_WIDTH-1:0] PageStep = ADDR_WIDTH'(PAGE_SIZE);

  logic [15:0]           crc_q, crc_d;
  logic [IdxW-1:0]       fill_q, fill_d;
  logic [ADDR_WIDTH-1:0] addr_q, addr_d;
  logic                  silent_q, silent_d;
  logic [1:0]            target_q, target_d;
  logic [7:0]            seq_q, seq_d;
  logic                  accept;
  logic                  push;
  cmd_t                  cmd;
  logic [ADDR_WIDTH+23:0] start_ext;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'h8408;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign start_ext  = {{ADDR_WIDTH{1'b0}}, start_address_i};

  always_comb begin
    crc_d    = crc_q;
    fill_d   = fill_q;
    addr_d   = addr_q;
    silent_d = silent_q;
    target_d = target_q;
    seq_d    = seq_q;
    push     = 1'b0;
    cmd      = '0;
    cmd.kind = KIND_WRITE;
    unique case (mode_e'(mode_i))
      MODE_PING: begin
        if (!silent_q) begin
          seq_d     = seq_q + 8'd1;
          push      = 1'b1;
          cmd.reply = 1'b1;
          cmd.kind  = KIND_PING;
          cmd.req   = requester_i;
          cmd.seq   = seq_q + 8'd1;
          cmd.crc   = crc_q;
        end
      end
      MODE_TARGET: begin
        target_d = target_memory_i;
      end
      MODE_RESET: begin
        push      = 1'b1;
        cmd.clear = 1'b1;
        addr_d    = '0;
        crc_d     = '0;
        fill_d    = '0;
        silent_d  = 1'b0;
      end
      MODE_ADDR: begin
        addr_d = start_ext[ADDR_WIDTH-1:0];
        fill_d = '0;
      end
      MODE_DATA: begin
        crc_d    = crc_feed(crc_q, data_byte_i);
        push     = 1'b1;
        cmd.wr   = 1'b1;
        cmd.data = data_byte_i;
        if (fill_q == LastIdx) begin
          cmd.commit = (target_q == TargetFlash);
          addr_d     = addr_q + PageStep;
          fill_d     = '0;
        end else begin
          fill_d = fill_q + IdxW'(1);
        end
      end
      MODE_FINISH: begin
        push       = (target_q == TargetFlash);
        cmd.commit = 1'b1;
        addr_d     = addr_q + PageStep;
        fill_d     = '0;
      end
      MODE_EXIT: begin
        push      = 1'b1;
        cmd.reply = 1'b1;
        cmd.kind  = KIND_LEAVE;
      end
      MODE_DEAF: begin
        silent_d = 1'b1;
      end
      default: begin
        silent_d = silent_q;
      end
    endcase
  end

  assign q_push_o = accept && push;
  assign q_cmd_o  = cmd;
  assign q_addr_o = addr_q;
  assign q_idx_o  = fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= '0;
      fill_q   <= '0;
      addr_q   <= '0;
      silent_q <= 1'b0;
      target_q <= TargetFlash;
      seq_q    <= '0;
    end else if (accept) begin
      crc_q    <= crc_d;
      fill_q   <= fill_d;
      addr_q   <= addr_d;
      silent_q <= silent_d;
      target_q <= target_d;
      seq_q    <= seq_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/plc_fifo.sv
`default_nettype none

module plc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q;
  logic             rptr_q;
  logic [1:0]       cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/plc_back.sv
`default_nettype none

module plc_back #(
  parameter int unsigned PAGE_SIZE  = plc_pkg::PageSizeDef,
  parameter int unsigned ADDR_WIDTH = plc_pkg::AddrWidthDef,
  localparam int unsigned IdxW      = $clog2(PAGE_SIZE)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire plc_pkg::cmd_t         q_cmd_i,
  input  wire logic [ADDR_WIDTH-1:0] q_addr_i,
  input  wire logic [IdxW-1:0]       q_idx_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [23:0]                write_address_o,
  output logic [7:0]                 write_byte_o,
  output logic                       last_o,
  output logic [15:0]                reply_destination_o,
  output logic [7:0]                 reply_sequence_o,
  output logic [15:0]                checksum_o
);
  import plc_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(PAGE_SIZE - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e                state_q;
  logic [7:0]            mem [PAGE_SIZE];
  logic [7:0]            rdata_q;
  logic [PAGE_SIZE-1:0]  valid_q;
  logic                  fill_q;
  logic [IdxW-1:0]       drain_idx_q;
  logic [ADDR_WIDTH-1:0] drain_addr_q;
  logic                  pend_q;
  logic                  pend_vld_q;
  logic                  pend_last_q;
  logic [ADDR_WIDTH-1:0] pend_addr_q;
  logic [ADDR_WIDTH+23:0] pend_addr_ext;
  logic                  out_valid_q;
  kind_e                 kind_q;
  logic [23:0]           waddr_q;
  logic [7:0]            wbyte_q;
  logic                  last_q;
  logic [15:0]           dest_q;
  logic [7:0]            seq_q;
  logic [15:0]           crc_q;
  logic                  can_load;
  logic                  pop;
  logic                  rd_go;
  logic [7:0]            pend_byte;

  assign can_load = !out_valid_q || !out_stall_i;
  // nothing leaves the queue while a read result still waits for the output register
  assign pop      = (state_q == ST_IDLE) && q_valid_i && !pend_q && (!q_cmd_i.reply || can_load);
  assign rd_go    = (state_q == ST_DRAIN) && (!pend_q || can_load);
  assign q_pop_o  = pop;

  assign pend_addr_ext = {24'd0, pend_addr_q};
  // entries not written since the last clear read as the fill value
  assign pend_byte     = pend_vld_q ? rdata_q : (fill_q ? FillByte : 8'h00);

  always_ff @(posedge clk_i) begin
    if (pop && q_cmd_i.wr) begin
      mem[q_idx_i] <= q_cmd_i.data;
    end
    if (rd_go) begin
      rdata_q <= mem[drain_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      fill_q       <= 1'b0;
      drain_idx_q  <= '0;
      drain_addr_q <= '0;
      pend_q       <= 1'b0;
      pend_vld_q   <= 1'b0;
      pend_last_q  <= 1'b0;
      pend_addr_q  <= '0;
      out_valid_q  <= 1'b0;
      kind_q       <= KIND_PING;
      waddr_q      <= '0;
      wbyte_q      <= '0;
      last_q       <= 1'b0;
      dest_q       <= '0;
      seq_q        <= '0;
      crc_q        <= '0;
    end else begin
      if (pop) begin
        if (q_cmd_i.clear) begin
          valid_q <= '0;
          fill_q  <= 1'b1;
        end
        if (q_cmd_i.wr) begin
          valid_q[q_idx_i] <= 1'b1;
        end
        if (q_cmd_i.commit) begin
          state_q      <= ST_DRAIN;
          drain_idx_q  <= '0;
          drain_addr_q <= q_addr_i;
        end
      end

      if (pend_q && can_load && !rd_go) begin
        pend_q <= 1'b0;
      end
      if (rd_go) begin
        pend_q       <= 1'b1;
        pend_vld_q   <= valid_q[drain_idx_q];
        pend_last_q  <= (drain_idx_q == LastIdx);
        pend_addr_q  <= drain_addr_q;
        drain_idx_q  <= drain_idx_q + IdxW'(1);
        drain_addr_q <= drain_addr_q + ADDR_WIDTH'(1);
        if (drain_idx_q == LastIdx) begin
          state_q <= ST_IDLE;
        end
      end

      if (pend_q && can_load) begin
        out_valid_q <= 1'b1;
        kind_q      <= KIND_WRITE;
        waddr_q     <= pend_addr_ext[23:0];
        wbyte_q     <= pend_byte;
        last_q      <= pend_last_q;
        dest_q      <= '0;
        seq_q       <= '0;
        crc_q       <= '0;
      end else if (pop && q_cmd_i.reply) begin
        out_valid_q <= 1'b1;
        kind_q      <= q_cmd_i.kind;
        waddr_q     <= '0;
        wbyte_q     <= '0;
        last_q      <= 1'b0;
        dest_q      <= q_cmd_i.req;
        seq_q       <= q_cmd_i.seq;
        crc_q       <= q_cmd_i.crc;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign kind_o              = kind_q;
  assign write_address_o     = waddr_q;
  assign write_byte_o        = wbyte_q;
  assign last_o              = last_q;
  assign reply_destination_o = dest_q;
  assign reply_sequence_o    = seq_q;
  assign checksum_o          = crc_q;

endmodule

`default_nettype wire

// File: rtl/page_loader_with_crc_core.sv
`default_nettype none

// channel   direction  handshake                  payload
// command   in         in_valid_i / in_stall_o    mode, data_byte, target_memory,
//                                                 start_address, requester
// result    out        out_valid_o / out_stall_i  kind, write_address, write_byte, last,
//                                                 reply_destination, reply_sequence, checksum
//
// one command per cycle is taken while the two-entry command queue has room.
// a flash page commit drains PAGE_SIZE write results at one per cycle, paced by the single
// read port of the page memory and held by output stall; input stalls once the queue is full.
// reset is asynchronous and clears all control state; the page memory itself has no
// reset, per-entry valid bits make unwritten entries read 0x00 (0xFF after a reset command).
// output stall backs up through the back end into the queue and then the input.

module page_loader_with_crc_core #(
  parameter int unsigned PAGE_SIZE  = plc_pkg::PageSizeDef,
  parameter int unsigned ADDR_WIDTH = plc_pkg::AddrWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [1:0]  target_memory_i,
  input  wire logic [23:0] start_address_i,
  input  wire logic [15:0] requester_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [23:0]      write_address_o,
  output logic [7:0]       write_byte_o,
  output logic             last_o,
  output logic [15:0]      reply_destination_o,
  output logic [7:0]       reply_sequence_o,
  output logic [15:0]      checksum_o
);
  import plc_pkg::*;

  localparam int unsigned IdxW   = $clog2(PAGE_SIZE);
  localparam int unsigned EntryW = $bits(cmd_t) + ADDR_WIDTH + IdxW;

  logic                  f_push;
  cmd_t                  f_cmd;
  logic [ADDR_WIDTH-1:0] f_addr;
  logic [IdxW-1:0]       f_idx;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [EntryW-1:0]     q_data;
  cmd_t                  b_cmd;
  logic [ADDR_WIDTH-1:0] b_addr;
  logic [IdxW-1:0]       b_idx;

  plc_front #(
    .PAGE_SIZE  (PAGE_SIZE),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .data_byte_i     (data_byte_i),
    .target_memory_i (target_memory_i),
    .start_address_i (start_address_i),
    .requester_i     (requester_i),
    .q_full_i        (q_full),
    .q_push_o        (f_push),
    .q_cmd_o         (f_cmd),
    .q_addr_o        (f_addr),
    .q_idx_o         (f_idx)
  );

  plc_fifo #(
    .WIDTH (EntryW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_data_i ({f_cmd, f_addr, f_idx}),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  assign {b_cmd, b_addr, b_idx} = q_data;

  plc_back #(
    .PAGE_SIZE  (PAGE_SIZE),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_cmd_i             (b_cmd),
    .q_addr_i            (b_addr),
    .q_idx_i             (b_idx),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .write_address_o     (write_address_o),
    .write_byte_o        (write_byte_o),
    .last_o              (last_o),
    .reply_destination_o (reply_destination_o),
    .reply_sequence_o    (reply_sequence_o),
    .checksum_o          (checksum_o)
  );

endmodule

`default_nettype wire

// File: sim/page_loader_with_crc_core_tb.sv
module page_loader_with_crc_core_tb;
  import plc_pkg::*;

  localparam int PAGE = PageSizeDef;
  localparam int LIMIT = 1200000;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  data;
    logic [1:0]  targ;
    logic [23:0] addr;
    logic [15:0] req;
    logic [3:0]  gap;
  } loader_cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] waddr;
    logic [7:0]  wbyte;
    logic        last;
    logic [15:0] dest;
    logic [7:0]  seq;
    logic [15:0] crc;
  } loader_out_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [1:0]  target_memory_i = '0;
  logic [23:0] start_address_i = '0;
  logic [15:0] requester_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [23:0] write_address_o;
  logic [7:0]  write_byte_o;
  logic        last_o;
  logic [15:0] reply_destination_o;
  logic [7:0]  reply_sequence_o;
  logic [15:0] checksum_o;

  page_loader_with_crc_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .data_byte_i        (data_byte_i),
    .target_memory_i    (target_memory_i),
    .start_address_i    (start_address_i),
    .requester_i        (requester_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .write_address_o    (write_address_o),
    .write_byte_o       (write_byte_o),
    .last_o             (last_o),
    .reply_destination_o(reply_destination_o),
    .reply_sequence_o   (reply_sequence_o),
    .checksum_o         (checksum_o)
  );

  // loader state as the testbench sees it
  logic [7:0]  page_mem [PAGE];
  int          fill_ptr;
  logic [23:0] base_addr;
  logic [15:0] crc_acc;
  bit          muted;
  logic [1:0]  dest_mem;
  logic [7:0]  ping_seq;

  loader_cmd_t cmd_backlog[$];
  loader_out_t due_results[$];
  loader_cmd_t cur_cmd;
  int          gap_cnt;
  int          stall_left;
  int          n_items;
  int          n_taken;
  int          n_checked;
  int          n_pages;
  int          n_pings;
  int          err_cnt;
  int          cycle_cnt;
  bit          calm_in;
  bit          calm_out;

  function automatic logic [15:0] crc_kermit_byte(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  task automatic commit_page();
    loader_out_t r;
    if (dest_mem == TargetFlash) begin
      for (int i = 0; i < PAGE; i++) begin
        r = '0;
        r.kind = KIND_WRITE;
        r.waddr = base_addr + 24'(i);
        r.wbyte = page_mem[i];
        r.last = (i == PAGE - 1);
        due_results.push_back(r);
      end
      n_pages++;
    end
    base_addr = base_addr + 24'(PAGE);
    fill_ptr = 0;
  endtask

  task automatic apply_loader_cmd(loader_cmd_t c);
    loader_out_t r;
    r = '0;
    case (c.mode)
      MODE_PING: begin
        if (!muted) begin
          ping_seq = ping_seq + 8'd1;
          r.kind = KIND_PING;
          r.dest = c.req;
          r.seq = ping_seq;
          r.crc = crc_acc;
          due_results.push_back(r);
          n_pings++;
        end
      end
      MODE_TARGET: dest_mem = c.targ;
      MODE_RESET: begin
        for (int i = 0; i < PAGE; i++) page_mem[i] = FillByte;
        base_addr = '0;
        crc_acc = '0;
        fill_ptr = 0;
        muted = 1'b0;
      end
      MODE_ADDR: begin
        base_addr = c.addr;
        fill_ptr = 0;
      end
      MODE_DATA: begin
        crc_acc = crc_kermit_byte(crc_acc, c.data);
        if (fill_ptr >= PAGE) fill_ptr = 0;
        page_mem[fill_ptr] = c.data;
        fill_ptr++;
        if (fill_ptr >= PAGE) commit_page();
      end
      MODE_FINISH: commit_page();
      MODE_EXIT: begin
        r.kind = KIND_LEAVE;
        due_results.push_back(r);
      end
      default: muted = 1'b1;
    endcase
  endtask

  task automatic add_cmd(mode_e m, logic [7:0] d, logic [1:0] t, logic [23:0] a,
                         logic [15:0] q);
    loader_cmd_t c;
    c.mode = m;
    c.data = d;
    c.targ = t;
    c.addr = a;
    c.req = q;
    c.gap = calm_in ? 4'd0 : 4'($urandom_range(0, 13));
    cmd_backlog.push_back(c);
    n_items++;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_loader_cmd(cur_cmd);
        n_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_backlog.size() != 0 && gap_cnt >= int'(cmd_backlog[0].gap)) begin
          cur_cmd = cmd_backlog.pop_front();
          gap_cnt = 0;
          mode_i <= cur_cmd.mode;
          data_byte_i <= cur_cmd.data;
          target_memory_i <= cur_cmd.targ;
          start_address_i <= cur_cmd.addr;
          requester_i <= cur_cmd.req;
          in_valid_i <= 1'b1;
        end else begin
          if (cmd_backlog.size() != 0) gap_cnt++;
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    loader_out_t got;
    loader_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.kind = kind_e'(kind_o);
        got.waddr = write_address_o;
        got.wbyte = write_byte_o;
        got.last = last_o;
        got.dest = reply_destination_o;
        got.seq = reply_sequence_o;
        got.crc = checksum_o;
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: kind %0d addr %h byte %h", kind_o,
                     write_address_o, write_byte_o);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch on result %0d:", n_checked);
              $display("  expected kind %0d addr %h byte %h last %b dest %h seq %h crc %h",
                       want.kind, want.waddr, want.wbyte, want.last, want.dest, want.seq,
                       want.crc);
              $display("  actual   kind %0d addr %h byte %h last %b dest %h seq %h crc %h",
                       got.kind, got.waddr, got.wbyte, got.last, got.dest, got.seq,
                       got.crc);
            end
          end
        end
        stall_left = calm_out ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // cycle count, receiver calm stretches, timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt % 512 == 0) calm_out = ($urandom_range(0, 3) == 0);
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;
    for (int i = 0; i < PAGE; i++) page_mem[i] = 8'h00;
    fill_ptr = 0;
    base_addr = '0;
    crc_acc = '0;
    muted = 1'b0;
    dest_mem = TargetFlash;
    ping_seq = '0;

    // directed commands
    add_cmd(MODE_PING, 8'($urandom), 2'($urandom), 24'($urandom), 16'h0000);
    add_cmd(MODE_PING, 8'($urandom), 2'($urandom), 24'($urandom), 16'hFFFF);
    add_cmd(MODE_EXIT, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_DATA, 8'h00, 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_DATA, 8'hFF, 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_PING, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    // partial page at the top of the address space wraps to zero
    add_cmd(MODE_ADDR, 8'($urandom), 2'($urandom), 24'hFFFFFF, 16'($urandom));
    add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_TARGET, 8'($urandom), 2'd1, 24'($urandom), 16'($urandom));
    add_cmd(MODE_DATA, 8'hA5, 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_TARGET, 8'($urandom), 2'd2, 24'($urandom), 16'($urandom));
    add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_TARGET, 8'($urandom), 2'd3, 24'($urandom), 16'($urandom));
    add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_TARGET, 8'($urandom), TargetFlash, 24'($urandom), 16'($urandom));
    add_cmd(MODE_RESET, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_DEAF, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_PING, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_EXIT, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_RESET, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_PING, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
    add_cmd(MODE_ADDR, 8'($urandom), 2'($urandom), 24'h000000, 16'($urandom));
    add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));

    // random part: mostly page loads, some loose commands
    while (n_items < 325) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        if ($urandom_range(0, 2) == 0)
          add_cmd(MODE_ADDR, 8'($urandom), 2'($urandom),
                  ($urandom_range(0, 3) == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 127))
                                              : 24'($urandom), 16'($urandom));
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
          add_cmd(MODE_DATA, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
        if ($urandom_range(0, 1) == 0)
          add_cmd(MODE_PING, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
        if ($urandom_range(0, 2) == 0)
          add_cmd(MODE_FINISH, 8'($urandom), 2'($urandom), 24'($urandom), 16'($urandom));
      end else begin
        add_cmd(mode_e'($urandom_range(0, 7)), 8'($urandom),
                ($urandom_range(0, 2) != 0) ? TargetFlash : 2'($urandom_range(1, 3)),
                24'($urandom), 16'($urandom));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_taken == n_items && due_results.size() == 0)) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (due_results.size() != 0) err_cnt++;
    $display("sent %0d commands, checked %0d results", n_taken, n_checked);
    $display("covered %0d flash page commits and %0d ping replies", n_pages, n_pings);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
